/* src/mtne_pkg.sv */
// Shared types and result codes for the MIDI track note extractor.
// Depends on nothing; every other file of the block imports it.
package mtne_pkg;

   // One input request: a raw track byte and its start-of-track mark.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       track_start;
   } mtne_req_type;

   // One result item.
   typedef struct packed {
      logic [1:0]  kind;
      logic [6:0]  note_number;
      logic [6:0]  note_velocity;
      logic [31:0] note_start;
      logic [31:0] duration;
   } mtne_rsp_type;

   // Result kinds.
   localparam logic [1:0] KIND_NOTE  = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // Commands from the byte parser to the note table.
   typedef struct packed {
      logic       rd_en;     // key byte seen: read the entry of rd_key
      logic [7:0] rd_key;
      logic       op_en;     // velocity byte seen: complete the message
      logic       note_on;
      logic       note_off;
      logic [7:0] key_byte;
      logic [7:0] vel_byte;
   } mtne_note_cmd_type;

endpackage

/* src/midi_track_note_extractor.sv */
// Top level of the MIDI track note extractor: parser, note table and result buffer.
// Depends on mtne_pkg, mtne_parser, mtne_note_table and mtne_out_buf.
//
// The block takes one byte of MIDI track event data per request and accepts a request
// in every cycle; each byte is parsed in the cycle it is accepted and yields at most
// one result, which is registered. The open notes live in a memory of NOTE_KEYS
// entries with a registered read: the read is issued on the key byte of a
// channel message and its data is ready by the velocity byte, so consecutive bytes
// never wait for the memory. Requests stall only while the skid entry holds a result:
// it fills when a result arrives while the output register is held, and it moves into
// the output register in the cycle that register is claimed, which still stalls. There
// is no clearing pass after reset or on a track start: all open-key flags are cleared
// at once.
module midi_track_note_extractor import mtne_pkg::*; #(
   parameter int NOTE_KEYS = 128,
   parameter int TIME_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  mtne_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output mtne_rsp_type rsp_data
);

   logic                 accept;
   logic [TIME_BITS-1:0] tick_time;
   mtne_note_cmd_type    note_cmd;
   logic                 clear_notes;
   logic                 par_res_valid, tbl_res_valid;
   mtne_rsp_type         par_res, tbl_res;
   logic                 track_ended;
   logic                 push;
   mtne_rsp_type         push_data;

   assign accept = req_valid & ~req_stall;

   mtne_parser #(
      .TIME_BITS(TIME_BITS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_data),
      .tick_time  (tick_time),
      .cmd        (note_cmd),
      .clear_notes(clear_notes),
      .res_valid  (par_res_valid),
      .res        (par_res),
      .track_ended(track_ended)
   );

   mtne_note_table #(
      .NOTE_KEYS(NOTE_KEYS),
      .TIME_BITS(TIME_BITS)
   ) u_note_table (
      .clock      (clock),
      .reset      (reset),
      .clear_notes(clear_notes),
      .cmd        (note_cmd),
      .tick_time  (tick_time),
      .res_valid  (tbl_res_valid),
      .res        (tbl_res)
   );

   // At most one source has a result for a given byte.
   assign push      = par_res_valid | tbl_res_valid;
   assign push_data = par_res_valid ? par_res : tbl_res;

   mtne_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .full     (req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   // The skid entry is only ever used behind a held output register.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("skid entry holds a result while the output register is empty");

   // Parser and note table never report on the same byte.
   a_single_source: assert property (@(posedge clock) disable iff (reset)
      !(par_res_valid && tbl_res_valid))
      else $error("parser and note table produced results for one byte");

   // A start-of-track byte always reopens the track.
   a_track_reopen: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.track_start) |=> !track_ended)
      else $error("track still marked ended after a track start");

   // A result arriving while the output is held fills the skid entry.
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      (push && rsp_valid && rsp_stall) |=> req_stall)
      else $error("result pushed into a held output was not kept");

endmodule

/* src/mtne_parser.sv */
// Byte parser of the note extractor: delta times, running status, sysex and meta skips.
// Depends on mtne_pkg; issues commands to mtne_note_table.
module mtne_parser import mtne_pkg::*; #(
   parameter int TIME_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  mtne_req_type         req,
   output logic [TIME_BITS-1:0] tick_time,
   output mtne_note_cmd_type    cmd,
   output logic                 clear_notes,
   output logic                 res_valid,
   output mtne_rsp_type         res,
   output logic                 track_ended
);

   localparam logic [7:0] SYS_PREFIX  = 8'hF0;
   localparam logic [7:0] SYSEX_ESC   = 8'hF7;
   localparam logic [7:0] META_PREFIX = 8'hFF;
   localparam logic [7:0] META_END    = 8'h2F;
   localparam logic [3:0] OP_NOTE_OFF = 4'h8;
   localparam logic [3:0] OP_NOTE_ON  = 4'h9;
   localparam logic [3:0] OP_PROGRAM  = 4'hC;
   localparam logic [3:0] OP_PRESSURE = 4'hD;

   typedef enum logic [7:0] {
      PH_DELTA     = 8'b0000_0001,
      PH_STATUS    = 8'b0000_0010,
      PH_DATA1     = 8'b0000_0100,
      PH_DATA2     = 8'b0000_1000,
      PH_SYSEX_LEN = 8'b0001_0000,
      PH_META_TYPE = 8'b0010_0000,
      PH_META_LEN  = 8'b0100_0000,
      PH_SKIP      = 8'b1000_0000
   } parse_phase_type;

   // Program change and channel pressure carry a single data byte.
   function automatic logic one_data_byte(input logic [7:0] status);
      return (status[7:4] == OP_PROGRAM) || (status[7:4] == OP_PRESSURE);
   endfunction

   parse_phase_type      phase_ff, phase_in, phase_cur;
   logic [7:0]           status_ff, status_in, status_cur;
   logic [7:0]           first_ff, first_in;
   logic [31:0]          acc_ff, acc_in, acc_cur, acc_shift;
   logic [31:0]          skip_ff, skip_in;
   logic [7:0]           meta_ff, meta_in;
   logic [TIME_BITS-1:0] tick_ff, tick_in, tick_cur;
   logic                 ended_ff, ended_in, ended_cur;
   logic [TIME_BITS+31:0] acc_wide;
   logic [7:0]           b;
   logic                 more;
   logic                 finish;

   assign b    = req.data_byte;
   assign more = b[7];

   // A start-of-track byte sees cleared time, status and phase before it is parsed.
   assign phase_cur  = req.track_start ? PH_DELTA : phase_ff;
   assign status_cur = req.track_start ? 8'h00 : status_ff;
   assign acc_cur    = req.track_start ? 32'h0 : acc_ff;
   assign tick_cur   = req.track_start ? '0 : tick_ff;
   assign ended_cur  = req.track_start ? 1'b0 : ended_ff;

   assign acc_shift = {acc_cur[24:0], b[6:0]};
   assign acc_wide  = {{TIME_BITS{1'b0}}, acc_shift};

   // Next-state logic of the event parser.
   always_comb begin
      phase_in  = phase_cur;
      status_in = status_cur;
      first_in  = first_ff;
      acc_in    = acc_cur;
      skip_in   = skip_ff;
      meta_in   = meta_ff;
      tick_in   = tick_cur;
      ended_in  = ended_cur;
      cmd       = '0;
      res_valid = 1'b0;
      res       = '0;
      finish    = 1'b0;
      if (!ended_cur) begin
         case (phase_cur)
            PH_DELTA: begin
               acc_in = acc_shift;
               if (!more) begin
                  tick_in  = tick_cur + acc_wide[TIME_BITS-1:0];
                  acc_in   = 32'h0;
                  phase_in = PH_STATUS;
               end
            end
            PH_STATUS: begin
               if (!more) begin
                  if (status_cur == 8'h00) begin
                     phase_in  = PH_DELTA;
                     res_valid = 1'b1;
                     res.kind  = KIND_ERROR;
                  end else begin
                     first_in = b;
                     if (one_data_byte(status_cur)) begin
                        phase_in = PH_DELTA;
                     end else begin
                        phase_in   = PH_DATA2;
                        cmd.rd_en  = 1'b1;
                        cmd.rd_key = b;
                     end
                  end
               end else if (b < SYS_PREFIX) begin
                  status_in = b;
                  phase_in  = PH_DATA1;
               end else begin
                  status_in = 8'h00;
                  acc_in    = 32'h0;
                  if (b == SYS_PREFIX || b == SYSEX_ESC) begin
                     meta_in  = 8'h00;
                     phase_in = PH_SYSEX_LEN;
                  end else if (b == META_PREFIX) begin
                     phase_in = PH_META_TYPE;
                  end else begin
                     phase_in  = PH_DELTA;
                     res_valid = 1'b1;
                     res.kind  = KIND_ERROR;
                  end
               end
            end
            PH_DATA1: begin
               first_in = b;
               if (one_data_byte(status_cur)) begin
                  phase_in = PH_DELTA;
               end else begin
                  phase_in   = PH_DATA2;
                  cmd.rd_en  = 1'b1;
                  cmd.rd_key = b;
               end
            end
            PH_DATA2: begin
               phase_in     = PH_DELTA;
               cmd.op_en    = 1'b1;
               cmd.note_on  = (status_cur[7:4] == OP_NOTE_ON) && (b != 8'h00);
               cmd.note_off = (status_cur[7:4] == OP_NOTE_OFF) ||
                              ((status_cur[7:4] == OP_NOTE_ON) && (b == 8'h00));
               cmd.key_byte = first_ff;
               cmd.vel_byte = b;
            end
            PH_META_TYPE: begin
               meta_in  = b;
               acc_in   = 32'h0;
               phase_in = PH_META_LEN;
            end
            PH_SYSEX_LEN, PH_META_LEN: begin
               acc_in = acc_shift;
               if (!more) begin
                  skip_in = acc_shift;
                  acc_in  = 32'h0;
                  if (acc_shift == 32'h0) begin
                     finish = 1'b1;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
            end
            PH_SKIP: begin
               skip_in = skip_ff - 32'd1;
               if (skip_ff == 32'd1) begin
                  finish = 1'b1;
               end
            end
            default: begin
               phase_in = PH_DELTA;
            end
         endcase
      end
      // The end of a skip closes the event; a skipped end-of-track meta ends the track.
      if (finish) begin
         phase_in = PH_DELTA;
         if (meta_ff == META_END) begin
            ended_in  = 1'b1;
            res_valid = 1'b1;
            res.kind  = KIND_END;
         end
      end
      if (!accept) begin
         cmd       = '0;
         res_valid = 1'b0;
      end
   end

   // Parser state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_DELTA;
         status_ff <= 8'h00;
         first_ff  <= 8'h00;
         acc_ff    <= 32'h0;
         skip_ff   <= 32'h0;
         meta_ff   <= 8'h00;
         tick_ff   <= '0;
         ended_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         status_ff <= status_in;
         first_ff  <= first_in;
         acc_ff    <= acc_in;
         skip_ff   <= skip_in;
         meta_ff   <= meta_in;
         tick_ff   <= tick_in;
         ended_ff  <= ended_in;
      end
   end

   assign tick_time   = tick_ff;
   assign clear_notes = accept & req.track_start;
   assign track_ended = ended_ff;

endmodule

/* src/mtne_note_table.sv */
// Note table of the note extractor: start time and velocity of each open key in a memory.
// Depends on mtne_pkg; driven by the commands of mtne_parser.
module mtne_note_table import mtne_pkg::*; #(
   parameter int NOTE_KEYS = 128,
   parameter int TIME_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear_notes,
   input  mtne_note_cmd_type    cmd,
   input  logic [TIME_BITS-1:0] tick_time,
   output logic                 res_valid,
   output mtne_rsp_type         res
);

   localparam int KEY_BITS   = $clog2(NOTE_KEYS);
   localparam int ENTRY_BITS = TIME_BITS + 7;

   // Key byte modulo the table depth; the byte stays below twice the depth.
   function automatic logic [KEY_BITS-1:0] key_index(input logic [7:0] key);
      logic [8:0] wide;
      logic [8:0] diff;
      wide = {1'b0, key};
      diff = wide - 9'(NOTE_KEYS);
      return (wide >= 9'(NOTE_KEYS)) ? diff[KEY_BITS-1:0] : wide[KEY_BITS-1:0];
   endfunction

   logic [ENTRY_BITS-1:0] note_mem [NOTE_KEYS];
   logic [ENTRY_BITS-1:0] rd_data_ff;
   logic [NOTE_KEYS-1:0]  valid_ff, valid_in;
   logic [KEY_BITS-1:0]   rd_idx, op_idx;
   logic                  hit, write_en, release_en;
   logic [TIME_BITS-1:0]  start_t, dur_t;
   logic [TIME_BITS+31:0] start_wide, dur_wide;

   assign rd_idx     = key_index(cmd.rd_key);
   assign op_idx     = key_index(cmd.key_byte);
   assign hit        = valid_ff[op_idx];
   assign write_en   = cmd.op_en & cmd.note_on & ~hit;
   assign release_en = cmd.op_en & cmd.note_off & hit;

   // The read is issued on the key byte, so its data waits in rd_data_ff for the
   // velocity byte. Writes only happen on velocity bytes, never in the same cycle.
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= note_mem[rd_idx];
      end
      if (write_en) begin
         note_mem[op_idx] <= {tick_time, cmd.vel_byte[6:0]};
      end
   end

   // Open-key flags; a new track clears them all at once.
   always_comb begin
      valid_in = valid_ff;
      if (clear_notes) begin
         valid_in = '0;
      end else begin
         if (write_en) begin
            valid_in[op_idx] = 1'b1;
         end
         if (release_en) begin
            valid_in[op_idx] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Completed note: start from the entry, duration wraps at the time width.
   assign start_t    = rd_data_ff[ENTRY_BITS-1:7];
   assign dur_t      = tick_time - start_t;
   assign start_wide = {32'h0, start_t};
   assign dur_wide   = {32'h0, dur_t};

   always_comb begin
      res_valid         = release_en;
      res.kind          = KIND_NOTE;
      res.note_number   = cmd.key_byte[6:0];
      res.note_velocity = rd_data_ff[6:0];
      res.note_start    = start_wide[31:0];
      res.duration      = dur_wide[31:0];
   end

endmodule

/* src/mtne_out_buf.sv */
// Result register with one skid entry for the note extractor's result channel.
// Depends on mtne_pkg for the result type.
module mtne_out_buf import mtne_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  mtne_rsp_type push_data,
   output logic         full,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output mtne_rsp_type rsp_data
);

   logic         out_valid_ff, skid_valid_ff;
   mtne_rsp_type out_data_ff, skid_data_ff;
   logic         take;

   assign take = out_valid_ff & ~rsp_stall;

   // Control: the skid entry fills only when the output register is held.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_valid_ff && !take) begin
         if (push) begin
            skid_valid_ff <= 1'b1;
         end
      end else if (skid_valid_ff) begin
         out_valid_ff  <= 1'b1;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= push;
      end
   end

   // Payload follows the same choice.
   always_ff @(posedge clock) begin
      if (out_valid_ff && !take) begin
         if (push) begin
            skid_data_ff <= push_data;
         end
      end else if (skid_valid_ff) begin
         out_data_ff <= skid_data_ff;
      end else if (push) begin
         out_data_ff <= push_data;
      end
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
